// ===== rtl/lkhc_pkg.sv =====
// shared types and codes for the keyed header cache
package lkhc_pkg;

    // operation codes
    localparam logic [2:0] OP_PUT    = 3'd0;
    localparam logic [2:0] OP_FIND_N = 3'd1;
    localparam logic [2:0] OP_FIND_H = 3'd2;
    localparam logic [2:0] OP_LATEST = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    // default slot count
    localparam int ENTRIES_DEF = 256;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] chain_key;
        logic [63:0] block_num;
        logic [63:0] key_hash_w0;
        logic [63:0] key_hash_w1;
        logic [63:0] key_hash_w2;
        logic [63:0] key_hash_w3;
        logic [31:0] payload_handle;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [7:0]  slot_index;
        logic [63:0] hit_block_num;
        logic [63:0] hit_hash_w0;
        logic [63:0] hit_hash_w1;
        logic [63:0] hit_hash_w2;
        logic [63:0] hit_hash_w3;
        logic [31:0] hit_payload;
    } t_out_item;

    // one memory row per slot, stamp zero means empty
    typedef struct packed {
        logic [63:0] chain;
        logic [63:0] number;
        logic [63:0] h0;
        logic [63:0] h1;
        logic [63:0] h2;
        logic [63:0] h3;
        logic [31:0] payload;
        logic [63:0] stamp;
    } t_row;

endpackage

// ===== rtl/lkhc_ram.sv =====
// generic single write port, single read port ram with registered read
module lkhc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/lru_keyed_header_cache_unit.sv =====
// Keyed header cache top level: fully associative slots held in one ram row
// each. Every lookup, and every put with a nonzero handle, reads all ENTRIES
// rows once through the single ram read port. A lookup is taken, scanned and
// answered, and the next request is then taken in the idle state. A put
// passes through an evict state after the scan to empty a slot whose hash no
// longer matches. A clear writes every row back to empty and then answers.
// After reset a clearing pass over all ENTRIES rows runs before the first
// transfer is taken. Invalid codes and zero-handle puts skip the scan and go
// straight to the done state to answer. A stalled result holds the block in
// its final state, and a new request is taken once that result has been
// parked in the output register.
module lru_keyed_header_cache_unit #(
    parameter int ENTRIES = lkhc_pkg::ENTRIES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lkhc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lkhc_pkg::t_out_item o_out_data
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = AW + 1;
    localparam int RW = $bits(lkhc_pkg::t_row);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_CLEAR = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;
    localparam logic [2:0] S_EVICT = 3'd5;

    logic [2:0]          r_state;
    logic [CW-1:0]       r_rd;
    logic                r_cv;
    logic [AW-1:0]       r_cidx;
    lkhc_pkg::t_in_item  r_req;
    logic [63:0]         r_ctr;
    logic                r_hit_ok;
    logic                r_hit_heq;
    logic [AW-1:0]       r_hit_idx;
    lkhc_pkg::t_row      r_hit_row;
    logic                r_free_ok;
    logic [AW-1:0]       r_free_idx;
    logic                r_min_ok;
    logic [AW-1:0]       r_min_idx;
    logic [63:0]         r_min_stamp;
    logic                r_out_vld;
    lkhc_pkg::t_out_item r_out;
    lkhc_pkg::t_out_item n_out;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    lkhc_pkg::t_row      ram_wdata;
    logic [RW-1:0]       ram_rdata;
    lkhc_pkg::t_row      d;

    logic                live, ceq, neq, heq, num_hit;
    logic                sweep_end, take_in, finish, is_put, is_look;
    logic [63:0]         n_stamp;
    logic [AW-1:0]       put_slot;

    lkhc_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // row compare against the held request
    always_comb begin
        d       = lkhc_pkg::t_row'(ram_rdata);
        live    = (d.stamp != 64'd0);
        ceq     = (d.chain == r_req.chain_key);
        neq     = (d.number == r_req.block_num);
        heq     = (d.h0 == r_req.key_hash_w0) && (d.h1 == r_req.key_hash_w1) &&
                  (d.h2 == r_req.key_hash_w2) && (d.h3 == r_req.key_hash_w3);
        num_hit = live && ceq && neq;
    end

    // request decode and finishing values
    assign sweep_end = (r_rd == CW'(ENTRIES - 1));
    assign take_in   = (r_state == S_IDLE) && i_in_valid;
    assign finish    = (r_state == S_DONE) && (!r_out_vld || !i_out_stall);
    assign is_put    = (r_req.op == lkhc_pkg::OP_PUT) && (r_req.payload_handle != 32'd0);
    assign is_look   = (r_req.op == lkhc_pkg::OP_FIND_N) || (r_req.op == lkhc_pkg::OP_FIND_H) ||
                       (r_req.op == lkhc_pkg::OP_LATEST);
    assign n_stamp   = (r_ctr == '1) ? r_ctr : r_ctr + 64'd1;
    assign put_slot  = (r_hit_ok && r_hit_heq) ? r_hit_idx :
                       (r_free_ok ? r_free_idx : r_min_idx);

    // ram write: sweep to empty, stale slot to empty, put row or stamp refresh
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_rd[AW-1:0];
        ram_wdata = '0;
        if (r_state == S_INIT || r_state == S_CLEAR) begin
            ram_we = 1'b1;
        end else if (r_state == S_EVICT && r_hit_ok && !r_hit_heq) begin
            ram_we    = 1'b1;
            ram_waddr = r_hit_idx;
        end else if (finish && is_put) begin
            ram_we    = 1'b1;
            ram_waddr = put_slot;
            ram_wdata = '{chain: r_req.chain_key, number: r_req.block_num,
                          h0: r_req.key_hash_w0, h1: r_req.key_hash_w1,
                          h2: r_req.key_hash_w2, h3: r_req.key_hash_w3,
                          payload: r_req.payload_handle, stamp: n_stamp};
        end else if (finish && is_look && r_hit_ok && r_hit_row.payload != 32'd0) begin
            ram_we          = 1'b1;
            ram_waddr       = r_hit_idx;
            ram_wdata       = r_hit_row;
            ram_wdata.stamp = n_stamp;
        end
    end

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_rd      <= '0;
            r_cv      <= 1'b0;
            r_ctr     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (finish) begin
                r_out_vld <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    r_rd <= r_rd + CW'(1);
                    if (sweep_end) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_rd <= '0;
                    r_cv <= 1'b0;
                    if (take_in) begin
                        if (i_in_data.op == lkhc_pkg::OP_CLEAR) begin
                            r_state <= S_CLEAR;
                        end else if ((i_in_data.op == lkhc_pkg::OP_PUT &&
                                      i_in_data.payload_handle != 32'd0) ||
                                     i_in_data.op == lkhc_pkg::OP_FIND_N ||
                                     i_in_data.op == lkhc_pkg::OP_FIND_H ||
                                     i_in_data.op == lkhc_pkg::OP_LATEST) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    r_cv   <= (r_rd != CW'(ENTRIES));
                    r_cidx <= r_rd[AW-1:0];
                    if (r_rd != CW'(ENTRIES)) begin
                        r_rd <= r_rd + CW'(1);
                    end
                    if (r_cv && r_cidx == AW'(ENTRIES - 1)) begin
                        if (is_put) begin
                            r_state <= S_EVICT;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_EVICT: begin
                    r_state <= S_DONE;
                end
                S_CLEAR: begin
                    r_rd  <= r_rd + CW'(1);
                    r_ctr <= '0;
                    if (sweep_end) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (finish) begin
                        r_state <= S_IDLE;
                        if (is_put || (is_look && r_hit_ok && r_hit_row.payload != 32'd0)) begin
                            r_ctr <= n_stamp;
                        end
                    end
                end
                default: begin
                    r_state <= S_INIT;
                end
            endcase
        end
    end

    // scan trackers: first match, best latest, first free, oldest stamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_ok  <= 1'b0;
            r_free_ok <= 1'b0;
            r_min_ok  <= 1'b0;
        end else if (take_in) begin
            r_req     <= i_in_data;
            r_hit_ok  <= 1'b0;
            r_free_ok <= 1'b0;
            r_min_ok  <= 1'b0;
        end else if (r_state == S_SCAN && r_cv) begin
            unique case (r_req.op)
                lkhc_pkg::OP_PUT: begin
                    if (!r_hit_ok && num_hit) begin
                        r_hit_ok  <= 1'b1;
                        r_hit_heq <= heq;
                        r_hit_idx <= r_cidx;
                    end
                    if (!r_free_ok && (!live || (!r_hit_ok && num_hit && !heq))) begin
                        r_free_ok  <= 1'b1;
                        r_free_idx <= r_cidx;
                    end
                    if (!r_min_ok || d.stamp < r_min_stamp) begin
                        r_min_ok    <= 1'b1;
                        r_min_idx   <= r_cidx;
                        r_min_stamp <= d.stamp;
                    end
                end
                lkhc_pkg::OP_FIND_N: begin
                    if (!r_hit_ok && num_hit) begin
                        r_hit_ok  <= 1'b1;
                        r_hit_idx <= r_cidx;
                        r_hit_row <= d;
                    end
                end
                lkhc_pkg::OP_FIND_H: begin
                    if (!r_hit_ok && live && ceq && heq) begin
                        r_hit_ok  <= 1'b1;
                        r_hit_idx <= r_cidx;
                        r_hit_row <= d;
                    end
                end
                lkhc_pkg::OP_LATEST: begin
                    if (live && ceq && d.payload != 32'd0 &&
                        (!r_hit_ok || d.number > r_hit_row.number)) begin
                        r_hit_ok  <= 1'b1;
                        r_hit_idx <= r_cidx;
                        r_hit_row <= d;
                    end
                end
                default: begin
                    r_hit_ok <= r_hit_ok;
                end
            endcase
        end
    end

    // next result value
    always_comb begin
        n_out = '0;
        if (is_put) begin
            n_out.slot_index    = 8'(put_slot);
            n_out.hit_block_num = r_req.block_num;
            n_out.hit_hash_w0   = r_req.key_hash_w0;
            n_out.hit_hash_w1   = r_req.key_hash_w1;
            n_out.hit_hash_w2   = r_req.key_hash_w2;
            n_out.hit_hash_w3   = r_req.key_hash_w3;
            n_out.hit_payload   = r_req.payload_handle;
        end else if (is_look && r_hit_ok && r_hit_row.payload != 32'd0) begin
            n_out.found         = 1'b1;
            n_out.slot_index    = 8'(r_hit_idx);
            n_out.hit_block_num = r_hit_row.number;
            n_out.hit_hash_w0   = r_hit_row.h0;
            n_out.hit_hash_w1   = r_hit_row.h1;
            n_out.hit_hash_w2   = r_hit_row.h2;
            n_out.hit_hash_w3   = r_hit_row.h3;
            n_out.hit_payload   = r_hit_row.payload;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out <= n_out;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/lkhc_checker.sv =====
// port-level checks for the keyed header cache
module lkhc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_stall,
    input logic                o_out_valid,
    input lkhc_pkg::t_out_item o_out_data
);

    // a hit always carries a live handle
    a_hit_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.found |-> o_out_data.hit_payload != 32'd0)
        else $error("hit without payload");

    // a miss or empty result has zero slot index, block number and first hash word
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.found && o_out_data.hit_payload == 32'd0 |->
        o_out_data.slot_index == 8'd0 && o_out_data.hit_block_num == 64'd0 &&
        o_out_data.hit_hash_w0 == 64'd0)
        else $error("miss result not cleared");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

endmodule

bind lru_keyed_header_cache_unit lkhc_checker u_lkhc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_stall (i_out_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data)
);
